// ===== hdl/tshf_pkg.sv =====
// ----------------------------------------------------------------------------
// tshf_pkg
// Shared types, lamp mode codes, register indexes and reset values for the
// turn signal and hazard flasher.
// ----------------------------------------------------------------------------
package tshf_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned MODE_W = 3;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SET = 1'b1;

	localparam logic [MODE_W-1:0] MODE_OFF = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LEFT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HAZARD = 3'd4;

	localparam logic [PHASE_W-1:0] PHASE_SHORT_ON_A = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_SHORT_OFF_A = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_SHORT_ON_B = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_SHORT_OFF_B = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_LONG_ON = 3'd4;
	localparam logic [PHASE_W-1:0] PHASE_LONG_OFF = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_ON = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_OFF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_ON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_OFF = 3'd4;

	localparam logic [TIME_W-1:0] RST_BLINK_HALF = 32'd333333;
	localparam logic [TIME_W-1:0] RST_SHORT_ON = 32'd100000;
	localparam logic [TIME_W-1:0] RST_SHORT_OFF = 32'd100000;
	localparam logic [TIME_W-1:0] RST_LONG_ON = 32'd400000;
	localparam logic [TIME_W-1:0] RST_LONG_OFF = 32'd100000;

	typedef struct packed {
		logic [TIME_W-1:0] blink_half_period_us;
		logic [TIME_W-1:0] short_on_len;
		logic [TIME_W-1:0] short_off_len;
		logic [TIME_W-1:0] long_on_len;
		logic [TIME_W-1:0] long_off_len;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic left;
		logic right;
		logic [TIME_W-1:0] toggle_time;
		logic [PHASE_W-1:0] phase;
		logic [TIME_W-1:0] hazard_start;
	} lamp_state_t;

endpackage

// ===== hdl/tshf_if.sv =====
// ----------------------------------------------------------------------------
// tshf request and result channels
// Valid/ready channels carrying flasher requests and lamp results.
// ----------------------------------------------------------------------------
interface tshf_item_if ();
	logic valid;
	logic ready;
	logic kind;
	logic [tshf_pkg::MODE_W-1:0] lamp_mode;
	logic [tshf_pkg::TIME_W-1:0] now_us;

	modport source (output valid, kind, lamp_mode, now_us, input ready);
	modport sink (input valid, kind, lamp_mode, now_us, output ready);
endinterface

interface tshf_result_if ();
	logic valid;
	logic ready;
	logic left_lamp;
	logic right_lamp;

	modport source (output valid, left_lamp, right_lamp, input ready);
	modport sink (input valid, left_lamp, right_lamp, output ready);
endinterface

// ===== hdl/tshf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tshf_cfg_regs
// Timing registers for blink and hazard patterns, written by index.
// ----------------------------------------------------------------------------
module tshf_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [tshf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [tshf_pkg::TIME_W-1:0] wr_data,
	output tshf_pkg::cfg_t cfg
);

	tshf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_half_period_us <= tshf_pkg::RST_BLINK_HALF;
			cfg_q.short_on_len <= tshf_pkg::RST_SHORT_ON;
			cfg_q.short_off_len <= tshf_pkg::RST_SHORT_OFF;
			cfg_q.long_on_len <= tshf_pkg::RST_LONG_ON;
			cfg_q.long_off_len <= tshf_pkg::RST_LONG_OFF;
		end else if (wr_en) begin
			case (wr_index)
				tshf_pkg::REG_BLINK_HALF: cfg_q.blink_half_period_us <= wr_data;
				tshf_pkg::REG_SHORT_ON: cfg_q.short_on_len <= wr_data;
				tshf_pkg::REG_SHORT_OFF: cfg_q.short_off_len <= wr_data;
				tshf_pkg::REG_LONG_ON: cfg_q.long_on_len <= wr_data;
				tshf_pkg::REG_LONG_OFF: cfg_q.long_off_len <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/tshf_lamp_core.sv =====
// ----------------------------------------------------------------------------
// tshf_lamp_core
// Next-state logic: mode selection, turn blink timer and hazard pattern.
// ----------------------------------------------------------------------------
module tshf_lamp_core (
	input  tshf_pkg::lamp_state_t cur,
	input  tshf_pkg::cfg_t cfg,
	input  logic kind,
	input  logic [tshf_pkg::MODE_W-1:0] lamp_mode,
	input  logic [tshf_pkg::TIME_W-1:0] now_us,
	output tshf_pkg::lamp_state_t nxt
);

	logic [tshf_pkg::PHASE_W-1:0] phase;
	logic [tshf_pkg::TIME_W-1:0] phase_len;
	logic [tshf_pkg::TIME_W-1:0] toggle_diff;
	logic [tshf_pkg::TIME_W-1:0] hazard_diff;
	logic toggle_due;
	logic phase_done;
	logic lit;

	assign phase = (cur.phase > tshf_pkg::PHASE_LONG_OFF) ? tshf_pkg::PHASE_SHORT_ON_A
		: cur.phase;
	assign toggle_diff = now_us - cur.toggle_time;
	assign hazard_diff = now_us - cur.hazard_start;
	assign toggle_due = toggle_diff > cfg.blink_half_period_us;
	assign phase_done = hazard_diff >= phase_len;
	assign lit = ~phase[0];

	always_comb begin
		case (phase)
			tshf_pkg::PHASE_SHORT_OFF_A, tshf_pkg::PHASE_SHORT_OFF_B:
				phase_len = cfg.short_off_len;
			tshf_pkg::PHASE_LONG_ON: phase_len = cfg.long_on_len;
			tshf_pkg::PHASE_LONG_OFF: phase_len = cfg.long_off_len;
			default: phase_len = cfg.short_on_len;
		endcase
	end

	always_comb begin
		nxt = cur;
		if (kind == tshf_pkg::KIND_SET) begin
			if (lamp_mode <= tshf_pkg::MODE_HAZARD) begin
				nxt.mode = lamp_mode;
				if (lamp_mode inside {tshf_pkg::MODE_LEFT, tshf_pkg::MODE_RIGHT}) begin
					nxt.toggle_time = now_us;
				end else if (lamp_mode == tshf_pkg::MODE_HAZARD) begin
					nxt.phase = tshf_pkg::PHASE_SHORT_ON_A;
					nxt.hazard_start = now_us;
				end
			end
		end else begin
			case (cur.mode)
				tshf_pkg::MODE_REVERSE: begin
					nxt.left = 1'b1;
					nxt.right = 1'b1;
				end
				tshf_pkg::MODE_LEFT: begin
					if (toggle_due) begin
						nxt.left = ~cur.left;
						nxt.toggle_time = now_us;
					end
					nxt.right = 1'b0;
				end
				tshf_pkg::MODE_RIGHT: begin
					if (toggle_due) begin
						nxt.right = ~cur.right;
						nxt.toggle_time = now_us;
					end
					nxt.left = 1'b0;
				end
				tshf_pkg::MODE_HAZARD: begin
					nxt.left = lit;
					nxt.right = lit;
					if (phase_done) begin
						nxt.phase = (phase == tshf_pkg::PHASE_LONG_OFF)
							? tshf_pkg::PHASE_SHORT_ON_A : phase + 3'd1;
						nxt.hazard_start = now_us;
					end
				end
				default: begin
					nxt.left = 1'b0;
					nxt.right = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hdl/turn_signal_hazard_flasher.sv =====
// ----------------------------------------------------------------------------
// turn_signal_hazard_flasher
// Two-lamp turn signal, reverse and hazard flasher driven by timestamps.
// ----------------------------------------------------------------------------
// Accepts one request per clock unless the result stalls: a set-mode request
// or a time tick. Each tick returns one result with both lamp states via the
// input register, then the result register; set-mode requests return nothing.
// The lamp state is updated between those registers, which sets the rate of
// one request per cycle. A stalled result is held in its register while a next
// request can still enter an empty input register. The user must write timing
// registers through wr_en/wr_index/wr_data only while no request is in flight;
// the block does not enforce this. Writes to an index above four are dropped.
module turn_signal_hazard_flasher (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [tshf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [tshf_pkg::TIME_W-1:0] wr_data,
	tshf_item_if.sink item,
	tshf_result_if.source result
);

	tshf_pkg::cfg_t cfg;
	tshf_pkg::lamp_state_t st_q;
	tshf_pkg::lamp_state_t st_nxt;

	logic valid_s1;
	logic kind_s1;
	logic [tshf_pkg::MODE_W-1:0] mode_s1;
	logic [tshf_pkg::TIME_W-1:0] now_s1;

	logic out_valid_q;
	logic left_q;
	logic right_q;
	logic advance;

	tshf_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.cfg(cfg)
	);

	tshf_lamp_core u_core (
		.cur(st_q),
		.cfg(cfg),
		.kind(kind_s1),
		.lamp_mode(mode_s1),
		.now_us(now_s1),
		.nxt(st_nxt)
	);

	assign advance = ~out_valid_q | result.ready;
	assign item.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1 <= item.kind;
			mode_s1 <= item.lamp_mode;
			now_s1 <= item.now_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (valid_s1 && advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && (kind_s1 == tshf_pkg::KIND_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && (kind_s1 == tshf_pkg::KIND_TICK)) begin
			left_q <= st_nxt.left;
			right_q <= st_nxt.right;
		end
	end

	assign result.valid = out_valid_q;
	assign result.left_lamp = left_q;
	assign result.right_lamp = right_q;

`ifndef SYNTHESIS
	a_set_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && kind_s1 == tshf_pkg::KIND_SET) |=> !out_valid_q)
		else $error("set-mode request produced a result");

	a_reverse_both_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && kind_s1 == tshf_pkg::KIND_TICK
			&& st_q.mode == tshf_pkg::MODE_REVERSE)
		|=> (out_valid_q && left_q && right_q))
		else $error("reverse tick without both lamps on");

	a_turn_other_off: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && kind_s1 == tshf_pkg::KIND_TICK
			&& (st_q.mode == tshf_pkg::MODE_LEFT || st_q.mode == tshf_pkg::MODE_RIGHT))
		|=> (out_valid_q && !(left_q && right_q)))
		else $error("turn signal lit both lamps");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode <= tshf_pkg::MODE_HAZARD && st_q.phase <= tshf_pkg::PHASE_LONG_OFF))
		else $error("mode or hazard phase out of range");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for turn_signal_hazard_flasher. Random-gapped requests (mode
// changes and time ticks) go in over the request channel while a predictor
// of the lamp logic builds the expected lamp results. The result channel
// stalls at random, and once for a long stretch. Each result is compared
// with the oldest prediction. Timing registers are reprogrammed between
// phases, covering reset values, all zeros, all ones and random values.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned PHASE_ITEMS = 155;
	localparam int unsigned NUM_PHASES = 6;
	localparam int unsigned MAX_REPORTS = 10;

	localparam logic [tshf_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd5;
	localparam logic [tshf_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd6;
	localparam logic [tshf_pkg::MODE_W-1:0] MODE_SPARE_C = 3'd7;

	localparam logic [tshf_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
	localparam logic [tshf_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
	localparam logic [tshf_pkg::CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

	typedef struct packed {
		logic kind;
		logic [tshf_pkg::MODE_W-1:0] lamp_mode;
		logic [tshf_pkg::TIME_W-1:0] now_us;
	} flasher_req_t;

	typedef struct packed {
		logic left;
		logic right;
	} lamp_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [tshf_pkg::CFG_IDX_W-1:0] wr_index = '0;
	logic [tshf_pkg::TIME_W-1:0] wr_data = '0;

	tshf_item_if req_ch ();
	tshf_result_if lamp_ch ();

	turn_signal_hazard_flasher i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.item(req_ch),
		.result(lamp_ch)
	);

	tshf_pkg::cfg_t timing;
	tshf_pkg::lamp_state_t lamps_now;

	flasher_req_t requests_pending[$];
	lamp_pair_t lamps_due[$];

	logic [tshf_pkg::TIME_W-1:0] gen_now;
	logic [tshf_pkg::TIME_W-1:0] gen_anchor;

	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned lamps_checked = 0;
	int unsigned ticks_taken = 0;
	int unsigned modes_taken = 0;
	int unsigned spare_taken = 0;
	int unsigned reg_writes = 0;
	int unsigned settings_used = 0;

	always #5 clk = ~clk;

	// lamp logic predictor, advanced once per accepted request
	function automatic void flasher_advance(input logic kind_i,
			input logic [tshf_pkg::MODE_W-1:0] mode_i,
			input logic [tshf_pkg::TIME_W-1:0] now_i, output logic emits,
			output lamp_pair_t lamps);
		logic [tshf_pkg::PHASE_W-1:0] ph;
		logic [tshf_pkg::TIME_W-1:0] span;
		logic [tshf_pkg::TIME_W-1:0] elapsed;
		emits = 1'b0;
		lamps = '0;
		if (kind_i == tshf_pkg::KIND_SET) begin
			if (mode_i <= tshf_pkg::MODE_HAZARD) begin
				lamps_now.mode = mode_i;
				if (mode_i == tshf_pkg::MODE_LEFT || mode_i == tshf_pkg::MODE_RIGHT) begin
					lamps_now.toggle_time = now_i;
				end else if (mode_i == tshf_pkg::MODE_HAZARD) begin
					lamps_now.phase = tshf_pkg::PHASE_SHORT_ON_A;
					lamps_now.hazard_start = now_i;
				end
			end
		end else begin
			case (lamps_now.mode)
				tshf_pkg::MODE_REVERSE: begin
					lamps_now.left = 1'b1;
					lamps_now.right = 1'b1;
				end
				tshf_pkg::MODE_LEFT: begin
					elapsed = now_i - lamps_now.toggle_time;
					if (elapsed > timing.blink_half_period_us) begin
						lamps_now.left = ~lamps_now.left;
						lamps_now.toggle_time = now_i;
					end
					lamps_now.right = 1'b0;
				end
				tshf_pkg::MODE_RIGHT: begin
					elapsed = now_i - lamps_now.toggle_time;
					if (elapsed > timing.blink_half_period_us) begin
						lamps_now.right = ~lamps_now.right;
						lamps_now.toggle_time = now_i;
					end
					lamps_now.left = 1'b0;
				end
				tshf_pkg::MODE_HAZARD: begin
					ph = (lamps_now.phase > tshf_pkg::PHASE_LONG_OFF)
						? tshf_pkg::PHASE_SHORT_ON_A : lamps_now.phase;
					case (ph)
						tshf_pkg::PHASE_SHORT_OFF_A, tshf_pkg::PHASE_SHORT_OFF_B:
							span = timing.short_off_len;
						tshf_pkg::PHASE_LONG_ON: span = timing.long_on_len;
						tshf_pkg::PHASE_LONG_OFF: span = timing.long_off_len;
						default: span = timing.short_on_len;
					endcase
					lamps_now.left = ~ph[0];
					lamps_now.right = ~ph[0];
					elapsed = now_i - lamps_now.hazard_start;
					if (elapsed >= span) begin
						lamps_now.phase = (ph == tshf_pkg::PHASE_LONG_OFF)
							? tshf_pkg::PHASE_SHORT_ON_A : ph + 1'b1;
						lamps_now.hazard_start = now_i;
					end
				end
				default: begin
					lamps_now.left = 1'b0;
					lamps_now.right = 1'b0;
				end
			endcase
			emits = 1'b1;
			lamps.left = lamps_now.left;
			lamps.right = lamps_now.right;
		end
	endfunction

	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		else if (r < 85) return $urandom_range(1, 3);
		else if (r < 97) return $urandom_range(4, 12);
		else return $urandom_range(20, 60);
	endfunction

	function automatic logic [tshf_pkg::TIME_W-1:0] pick_time(
			input logic [tshf_pkg::TIME_W-1:0] prev, input int unsigned span,
			input logic [tshf_pkg::TIME_W-1:0] anchor);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return prev + $urandom_range(0, span);
		else if (r < 78) return prev;
		else if (r < 86) return anchor - 1 - $urandom_range(0, 1);
		else if (r < 94) return $urandom;
		else return 32'hFFFF_FFF0 + $urandom_range(0, 31);
	endfunction

	function automatic void report_mismatch(input string what, input lamp_pair_t want,
			input lamp_pair_t got);
		if (mismatches < MAX_REPORTS)
			$display("mismatch: %s: expected left %0b right %0b, got left %0b right %0b",
				what, want.left, want.right, got.left, got.right);
		mismatches++;
	endfunction

	task automatic queue_request(input logic kind_i,
			input logic [tshf_pkg::MODE_W-1:0] mode_i,
			input logic [tshf_pkg::TIME_W-1:0] now_i);
		flasher_req_t q;
		q.kind = kind_i;
		q.lamp_mode = mode_i;
		q.now_us = now_i;
		requests_pending.push_back(q);
	endtask

	task automatic queue_random_traffic(input int unsigned count, input int unsigned span);
		int unsigned made;
		flasher_req_t q;
		made = 0;
		while (made < count) begin
			q.now_us = pick_time(gen_now, span, gen_anchor);
			if ($urandom_range(0, 99) < 9) begin
				q.kind = tshf_pkg::KIND_SET;
				if ($urandom_range(0, 6) == 0) begin
					q.lamp_mode = tshf_pkg::MODE_W'($urandom_range(MODE_SPARE_A,
						MODE_SPARE_C));
				end else begin
					q.lamp_mode = tshf_pkg::MODE_W'($urandom_range(tshf_pkg::MODE_OFF,
						tshf_pkg::MODE_HAZARD));
					gen_anchor = q.now_us;
					made++;
				end
			end else begin
				q.kind = tshf_pkg::KIND_TICK;
				q.lamp_mode = tshf_pkg::MODE_W'($urandom_range(tshf_pkg::MODE_OFF,
					MODE_SPARE_C));
				made++;
			end
			gen_now = q.now_us;
			requests_pending.push_back(q);
		end
	endtask

	task automatic write_reg(input logic [tshf_pkg::CFG_IDX_W-1:0] idx,
			input logic [tshf_pkg::TIME_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			tshf_pkg::REG_BLINK_HALF: timing.blink_half_period_us = val;
			tshf_pkg::REG_SHORT_ON: timing.short_on_len = val;
			tshf_pkg::REG_SHORT_OFF: timing.short_off_len = val;
			tshf_pkg::REG_LONG_ON: timing.long_on_len = val;
			tshf_pkg::REG_LONG_OFF: timing.long_off_len = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic program_timing(input tshf_pkg::cfg_t c);
		write_reg(tshf_pkg::REG_BLINK_HALF, c.blink_half_period_us);
		write_reg(tshf_pkg::REG_SHORT_ON, c.short_on_len);
		write_reg(tshf_pkg::REG_SHORT_OFF, c.short_off_len);
		write_reg(tshf_pkg::REG_LONG_ON, c.long_on_len);
		write_reg(tshf_pkg::REG_LONG_OFF, c.long_off_len);
		settings_used++;
	endtask

	task automatic wait_idle();
		while (requests_pending.size() != 0 || req_ch.valid || lamps_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// request driver
	int unsigned send_gap;
	int unsigned send_calm;
	logic tick_emits;
	lamp_pair_t tick_lamps;
	flasher_req_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= tshf_pkg::KIND_TICK;
			req_ch.lamp_mode <= tshf_pkg::MODE_OFF;
			req_ch.now_us <= '0;
			send_gap = 0;
			send_calm = 0;
			lamps_now = '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				flasher_advance(req_ch.kind, req_ch.lamp_mode, req_ch.now_us, tick_emits,
					tick_lamps);
				if (tick_emits) lamps_due.push_back(tick_lamps);
				if (req_ch.kind == tshf_pkg::KIND_TICK) ticks_taken++;
				else if (req_ch.lamp_mode <= tshf_pkg::MODE_HAZARD) modes_taken++;
				else spare_taken++;
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (requests_pending.size() > 0) begin
					next_req = requests_pending.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.kind <= next_req.kind;
					req_ch.lamp_mode <= next_req.lamp_mode;
					req_ch.now_us <= next_req.now_us;
					if (send_calm > 0) begin
						send_calm--;
						send_gap = 0;
					end else begin
						if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(30, 80);
						send_gap = idle_span();
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result ready, with one long hold-off to back the block up
	int unsigned hold_left;
	int unsigned take_calm;
	logic long_hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_ch.ready <= 1'b0;
			hold_left = 0;
			take_calm = 0;
			long_hold_done = 1'b0;
		end else begin
			if (!long_hold_done && lamps_checked >= 100) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				lamp_ch.ready <= 1'b0;
			end else if (take_calm > 0) begin
				take_calm--;
				lamp_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 3) begin
				take_calm = $urandom_range(30, 80);
				lamp_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 70) begin
				lamp_ch.ready <= 1'b1;
			end else begin
				hold_left = idle_span();
				lamp_ch.ready <= 1'b0;
			end
		end
	end

	// result checker
	lamp_pair_t due;
	lamp_pair_t seen;

	always @(posedge clk) begin
		if (arst_n && lamp_ch.valid && lamp_ch.ready) begin
			seen.left = lamp_ch.left_lamp;
			seen.right = lamp_ch.right_lamp;
			if (lamps_due.size() == 0) begin
				report_mismatch("lamp result with none expected", '0, seen);
			end else begin
				due = lamps_due.pop_front();
				if (due.left !== seen.left || due.right !== seen.right)
					report_mismatch("lamp state", due, seen);
			end
			lamps_checked++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycle_count,
				lamps_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	tshf_pkg::cfg_t next_cfg;
	int unsigned span_max;

	initial begin
		timing.blink_half_period_us = tshf_pkg::RST_BLINK_HALF;
		timing.short_on_len = tshf_pkg::RST_SHORT_ON;
		timing.short_off_len = tshf_pkg::RST_SHORT_OFF;
		timing.long_on_len = tshf_pkg::RST_LONG_ON;
		timing.long_off_len = tshf_pkg::RST_LONG_OFF;
		gen_now = '0;
		gen_anchor = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests at reset timing
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, 32'd0);
		queue_request(tshf_pkg::KIND_SET, MODE_SPARE_C, 32'd0);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, 32'hFFFF_FFFF);
		queue_request(tshf_pkg::KIND_SET, tshf_pkg::MODE_REVERSE, 32'd5);
		queue_request(tshf_pkg::KIND_TICK, MODE_SPARE_C, 32'd6);
		queue_request(tshf_pkg::KIND_SET, tshf_pkg::MODE_OFF, 32'd7);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_HAZARD, 32'd8);
		queue_request(tshf_pkg::KIND_SET, tshf_pkg::MODE_LEFT, 32'd1000);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF,
			32'd1000 + tshf_pkg::RST_BLINK_HALF);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF,
			32'd1001 + tshf_pkg::RST_BLINK_HALF);
		queue_request(tshf_pkg::KIND_SET, tshf_pkg::MODE_RIGHT, 32'hFFFF_FF00);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF,
			32'hFFFF_FF01 + tshf_pkg::RST_BLINK_HALF);
		queue_request(tshf_pkg::KIND_SET, tshf_pkg::MODE_HAZARD, 32'd10);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, 32'd10);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, 32'd100010);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, 32'd200010);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, 32'd300010);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, 32'd400010);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, 32'd800010);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, 32'd900010);
		queue_request(tshf_pkg::KIND_SET, MODE_SPARE_B, 32'd0);
		queue_request(tshf_pkg::KIND_TICK, MODE_SPARE_A, 32'd900011);
		queue_request(tshf_pkg::KIND_SET, tshf_pkg::MODE_HAZARD, 32'hFFFF_FFFF);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, tshf_pkg::RST_SHORT_ON - 1);
		queue_request(tshf_pkg::KIND_TICK, tshf_pkg::MODE_OFF, tshf_pkg::RST_SHORT_ON - 1);
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					next_cfg.blink_half_period_us = tshf_pkg::RST_BLINK_HALF;
					next_cfg.short_on_len = tshf_pkg::RST_SHORT_ON;
					next_cfg.short_off_len = tshf_pkg::RST_SHORT_OFF;
					next_cfg.long_on_len = tshf_pkg::RST_LONG_ON;
					next_cfg.long_off_len = tshf_pkg::RST_LONG_OFF;
				end
				1: next_cfg = '0;
				2: next_cfg = '1;
				3: begin
					next_cfg.blink_half_period_us = $urandom_range(1, 24);
					next_cfg.short_on_len = $urandom_range(1, 24);
					next_cfg.short_off_len = $urandom_range(1, 24);
					next_cfg.long_on_len = $urandom_range(1, 24);
					next_cfg.long_off_len = $urandom_range(1, 24);
				end
				4: begin
					next_cfg.blink_half_period_us = 32'hFFFF_FFFE;
					next_cfg.short_on_len = $urandom;
					next_cfg.short_off_len = $urandom;
					next_cfg.long_on_len = $urandom;
					next_cfg.long_off_len = $urandom;
				end
				default: begin
					next_cfg.blink_half_period_us = $urandom_range(1, 5000);
					next_cfg.short_on_len = $urandom_range(1, 5000);
					next_cfg.short_off_len = $urandom_range(1, 5000);
					next_cfg.long_on_len = $urandom_range(1, 5000);
					next_cfg.long_off_len = $urandom_range(1, 5000);
				end
			endcase
			program_timing(next_cfg);
			// writes past the last register must leave timing alone
			if (p == 3) begin
				write_reg(REG_SPARE_A, $urandom);
				write_reg(REG_SPARE_B, $urandom);
				write_reg(REG_SPARE_C, $urandom);
			end
			span_max = next_cfg.blink_half_period_us;
			if (next_cfg.short_on_len > span_max) span_max = next_cfg.short_on_len;
			if (next_cfg.short_off_len > span_max) span_max = next_cfg.short_off_len;
			if (next_cfg.long_on_len > span_max) span_max = next_cfg.long_on_len;
			if (next_cfg.long_off_len > span_max) span_max = next_cfg.long_off_len;
			queue_random_traffic(PHASE_ITEMS, (span_max >> 1) + 2);
			wait_idle();
		end

		$display("covered %0d ticks, %0d mode changes, %0d unknown mode codes, %0d register writes",
			ticks_taken, modes_taken, spare_taken, reg_writes);
		$display("%0d timing settings, %0d lamp results compared, %0d mismatches",
			settings_used, lamps_checked, mismatches);
		if (mismatches == 0 && lamps_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
